>>> rtl/core/cfvg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfvg_pkg
// Shared constants, register codes and types of the circle fan vertex generator.
// ----------------------------------------------------------------------------
package cfvg_pkg;

    localparam int MAX_SEGMENTS = 4096;
    localparam int ANGLE_BITS   = 16;
    localparam int N_TERMS      = 8;
    localparam int IDX_W        = 13;

    localparam logic [30:0] HALF_PI_Q30 = 31'h6487ED51;
    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
    localparam logic [31:0] XZ_COLOUR   = 32'hFFFF_FFEE;
    localparam logic [15:0] TEX_HALF    = 16'd16384;

    localparam logic [IDX_W-1:0] SEG_MIN = IDX_W'(3);
    localparam logic [IDX_W-1:0] SEG_MAX = IDX_W'(MAX_SEGMENTS);

    typedef enum logic [2:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_CENTER_Z  = 3'd2,
        REG_RADIUS    = 3'd3,
        REG_SEGMENTS  = 3'd4,
        REG_COLOUR    = 3'd5,
        REG_PLANE     = 3'd6
    } t_reg_idx;

    // series divisors: sine (2n)(2n+1), cosine (2n-1)(2n)
    localparam logic [8:0] SIN_DIV [N_TERMS] = '{
        9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272};
    localparam logic [8:0] COS_DIV [N_TERMS] = '{
        9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240};

    // floor(2^32 / d)
    localparam logic [31:0] SIN_RECIP [N_TERMS] = '{
        32'((64'd1 << 32) / 64'd6),   32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd156),
        32'((64'd1 << 32) / 64'd210), 32'((64'd1 << 32) / 64'd272)};
    localparam logic [31:0] COS_RECIP [N_TERMS] = '{
        32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 32) / 64'd12),
        32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd56),
        32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd132),
        32'((64'd1 << 32) / 64'd182), 32'((64'd1 << 32) / 64'd240)};

    typedef struct packed {
        logic [IDX_W-1:0] k;
        logic [IDX_W-1:0] third;
        logic             err;
        logic             ctr;
        logic [1:0]       quad;
    } t_side;

endpackage

>>> rtl/core/cfvg_vtx_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfvg_vtx_in_if
// Vertex number channel.
// ----------------------------------------------------------------------------
interface cfvg_vtx_in_if;
    logic        valid;
    logic        ready;
    logic [12:0] vertex_number;

    modport source (output valid, output vertex_number, input ready);
    modport sink   (input valid, input vertex_number, output ready);
endinterface

>>> rtl/core/cfvg_vtx_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfvg_vtx_out_if
// Vertex result channel.
// ----------------------------------------------------------------------------
interface cfvg_vtx_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [15:0] tex_u;
    logic        [15:0] tex_v;
    logic        [31:0] colour_out;
    logic               tri_valid;
    logic        [12:0] tri_second;
    logic        [12:0] tri_third;
    logic               index_error;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output tex_u, output tex_v, output colour_out, output tri_valid,
                    output tri_second, output tri_third, output index_error,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input tex_u, input tex_v, input colour_out, input tri_valid,
                    input tri_second, input tri_third, input index_error,
                    output ready);
endinterface

>>> rtl/core/circle_fan_vertex_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_fan_vertex_generator
// Rim and centre vertices of a circle fan mesh, with the fan triangle per rim vertex.
// ----------------------------------------------------------------------------
// Usage: write the circle registers through i_cfg_we / i_cfg_idx / i_cfg_data
// while no vertex is in flight, then stream vertex numbers on i_vtx. Each
// transfer on i_vtx gives one result transfer on o_vtx, in order.
// From input transfer to a valid result the pipe has one input stage,
// one stage per phase bit of the restoring divider (16), angle and
// x^2 stages (2), three stages per series term (24), trig fold, radius
// multiply and the output register (3).
// Throughput is one vertex per clock; the whole pipe moves as one and
// holds while a result waits in the output register with o_vtx.ready low,
// so nothing is lost or repeated under stall.
// Reset clears the pipe valid bits and loads the register defaults: centre
// at the origin, radius 1.0, 32 segments, white colour, XY plane.
// ----------------------------------------------------------------------------
module circle_fan_vertex_generator import cfvg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    cfvg_vtx_in_if.sink          i_vtx,
    cfvg_vtx_out_if.source       o_vtx
);

    localparam int DIV_ST = ANGLE_BITS;

    // configuration
    logic [31:0]      r_cx, r_cy, r_cz, r_colour;
    logic [30:0]      r_radius;
    logic [IDX_W-1:0] r_seg_cfg, w_segs;
    logic             r_plane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx      <= '0;
            r_cy      <= '0;
            r_cz      <= '0;
            r_radius  <= 31'd65536;
            r_seg_cfg <= IDX_W'(32);
            r_colour  <= 32'hFFFF_FFFF;
            r_plane   <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_CENTER_X: r_cx      <= i_cfg_data;
                REG_CENTER_Y: r_cy      <= i_cfg_data;
                REG_CENTER_Z: r_cz      <= i_cfg_data;
                REG_RADIUS:   r_radius  <= i_cfg_data[30:0];
                REG_SEGMENTS: r_seg_cfg <= i_cfg_data[IDX_W-1:0];
                REG_COLOUR:   r_colour  <= i_cfg_data;
                REG_PLANE:    r_plane   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_seg_cfg < SEG_MIN)      w_segs = SEG_MIN;
        else if (r_seg_cfg > SEG_MAX) w_segs = SEG_MAX;
        else                          w_segs = r_seg_cfg;
    end

    // pipe advances as a whole when the output slot is free or taken
    logic r_out_vld;
    logic w_en;
    assign w_en        = !r_out_vld || o_vtx.ready;
    assign i_vtx.ready = w_en;

    // input stage
    logic             r_in_vld;
    t_side            r_in_side;
    logic [IDX_W-1:0] r_in_rem;
    t_side            n_in_side;

    always_comb begin
        n_in_side.k     = i_vtx.vertex_number;
        n_in_side.err   = i_vtx.vertex_number > w_segs;
        n_in_side.ctr   = i_vtx.vertex_number == '0;
        n_in_side.third = (i_vtx.vertex_number == w_segs) ? IDX_W'(1)
                                                         : i_vtx.vertex_number + IDX_W'(1);
        n_in_side.quad  = '0;
    end

    // phase divider, one quotient bit per stage
    logic [DIV_ST-1:0] r_dv_vld;
    t_side             r_dv_side [DIV_ST];
    logic [IDX_W-1:0]  r_dv_rem  [DIV_ST];
    logic [DIV_ST-1:0] r_dv_q    [DIV_ST];
    logic [IDX_W-1:0]  n_dv_rem  [DIV_ST];
    logic [DIV_ST-1:0] n_dv_q    [DIV_ST];

    always_comb begin
        for (int g = 0; g < DIV_ST; g++) begin
            logic [IDX_W:0]    t;
            logic [DIV_ST-1:0] qp;
            t  = (g == 0) ? {r_in_rem, 1'b0} : {r_dv_rem[(g == 0) ? 0 : g-1], 1'b0};
            qp = (g == 0) ? '0 : r_dv_q[(g == 0) ? 0 : g-1];
            if (t >= {1'b0, w_segs}) begin
                n_dv_rem[g] = IDX_W'(t - {1'b0, w_segs});
                n_dv_q[g]   = {qp[DIV_ST-2:0], 1'b1};
            end else begin
                n_dv_rem[g] = t[IDX_W-1:0];
                n_dv_q[g]   = {qp[DIV_ST-2:0], 1'b0};
            end
        end
    end

    // angle and x^2 stages
    logic        r_ang_vld, r_sq_vld;
    t_side       r_ang_side, r_sq_side;
    t_side       n_ang_side;
    logic [30:0] r_ang_x, r_sq_x;
    logic [31:0] r_sq_x2;
    logic [60:0] n_ang_prod;
    logic [61:0] n_sq_prod;
    logic [DIV_ST-1:0] w_p;

    assign w_p        = r_dv_q[DIV_ST-1];
    assign n_ang_prod = 61'({w_p[DIV_ST-3:0], (32-ANGLE_BITS)'(0)}) * 61'(HALF_PI_Q30);
    assign n_sq_prod  = 62'(r_ang_x) * 62'(r_ang_x);

    always_comb begin
        n_ang_side      = r_dv_side[DIV_ST-1];
        n_ang_side.quad = w_p[DIV_ST-1:DIV_ST-2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_dv_vld  <= '0;
            r_ang_vld <= 1'b0;
            r_sq_vld  <= 1'b0;
        end else if (w_en) begin
            r_in_vld  <= i_vtx.valid;
            r_dv_vld  <= {r_dv_vld[DIV_ST-2:0], r_in_vld};
            r_ang_vld <= r_dv_vld[DIV_ST-1];
            r_sq_vld  <= r_ang_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_side <= n_in_side;
            r_in_rem  <= i_vtx.vertex_number - IDX_W'(1);
            for (int g = 0; g < DIV_ST; g++) begin
                r_dv_side[g] <= (g == 0) ? r_in_side : r_dv_side[(g == 0) ? 0 : g-1];
                r_dv_rem[g]  <= n_dv_rem[g];
                r_dv_q[g]    <= n_dv_q[g];
            end
            r_ang_side      <= n_ang_side;
            r_ang_x         <= n_ang_prod[60:30];
            r_sq_side       <= r_ang_side;
            r_sq_x          <= r_ang_x;
            r_sq_x2         <= n_sq_prod[61:30];
        end
    end

    // series terms
    logic               w_st_vld  [N_TERMS+1];
    t_side              w_st_side [N_TERMS+1];
    logic        [31:0] w_st_x2   [N_TERMS+1];
    logic        [31:0] w_st_ts   [N_TERMS+1];
    logic        [31:0] w_st_tc   [N_TERMS+1];
    logic signed [33:0] w_st_as   [N_TERMS+1];
    logic signed [33:0] w_st_ac   [N_TERMS+1];

    assign w_st_vld[0]  = r_sq_vld;
    assign w_st_side[0] = r_sq_side;
    assign w_st_x2[0]   = r_sq_x2;
    assign w_st_ts[0]   = {1'b0, r_sq_x};
    assign w_st_tc[0]   = ONE_Q30;
    assign w_st_as[0]   = $signed({3'b000, r_sq_x});
    assign w_st_ac[0]   = $signed({2'b00, ONE_Q30});

    for (genvar g = 0; g < N_TERMS; g++) begin : g_term
        cfvg_series_step u_step (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_vld    (w_st_vld[g]),
            .i_side   (w_st_side[g]),
            .i_x2     (w_st_x2[g]),
            .i_ts     (w_st_ts[g]),
            .i_tc     (w_st_tc[g]),
            .i_as     (w_st_as[g]),
            .i_ac     (w_st_ac[g]),
            .i_sdiv   (SIN_DIV[g]),
            .i_srecip (SIN_RECIP[g]),
            .i_cdiv   (COS_DIV[g]),
            .i_crecip (COS_RECIP[g]),
            .i_sub    ((g % 2) == 0),
            .o_vld    (w_st_vld[g+1]),
            .o_side   (w_st_side[g+1]),
            .o_x2     (w_st_x2[g+1]),
            .o_ts     (w_st_ts[g+1]),
            .o_tc     (w_st_tc[g+1]),
            .o_as     (w_st_as[g+1]),
            .o_ac     (w_st_ac[g+1])
        );
    end

    // clamp and quadrant fold
    logic               r_tr_vld;
    t_side              r_tr_side;
    logic        [30:0] r_tr_smag, r_tr_cmag;
    logic               r_tr_sneg, r_tr_cneg;
    logic        [30:0] n_bs, n_bc;
    logic signed [33:0] w_fas, w_fac;

    assign w_fas = w_st_as[N_TERMS];
    assign w_fac = w_st_ac[N_TERMS];

    always_comb begin
        if (w_fas < 0)                                n_bs = '0;
        else if (w_fas > $signed({2'b00, ONE_Q30}))   n_bs = ONE_Q30[30:0];
        else                                          n_bs = w_fas[30:0];
        if (w_fac < 0)                                n_bc = '0;
        else if (w_fac > $signed({2'b00, ONE_Q30}))   n_bc = ONE_Q30[30:0];
        else                                          n_bc = w_fac[30:0];
    end

    // rounding and scaling stage
    logic        r_ml_vld;
    t_side       r_ml_side;
    logic [61:0] r_ml_ps, r_ml_pc;
    logic        r_ml_sneg, r_ml_cneg;
    logic [14:0] r_ml_ts, r_ml_tc;
    logic [31:0] n_ts_round, n_tc_round;

    assign n_ts_round = (32'(r_tr_smag) + 32'h8000) >> 16;
    assign n_tc_round = (32'(r_tr_cmag) + 32'h8000) >> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tr_vld  <= 1'b0;
            r_ml_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_tr_vld  <= w_st_vld[N_TERMS];
            r_ml_vld  <= r_tr_vld;
            r_out_vld <= r_ml_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tr_side <= w_st_side[N_TERMS];
            case (w_st_side[N_TERMS].quad)
                2'd0: begin
                    r_tr_smag <= n_bs; r_tr_sneg <= 1'b0;
                    r_tr_cmag <= n_bc; r_tr_cneg <= 1'b0;
                end
                2'd1: begin
                    r_tr_smag <= n_bc; r_tr_sneg <= 1'b0;
                    r_tr_cmag <= n_bs; r_tr_cneg <= 1'b1;
                end
                2'd2: begin
                    r_tr_smag <= n_bs; r_tr_sneg <= 1'b1;
                    r_tr_cmag <= n_bc; r_tr_cneg <= 1'b1;
                end
                default: begin
                    r_tr_smag <= n_bc; r_tr_sneg <= 1'b1;
                    r_tr_cmag <= n_bs; r_tr_cneg <= 1'b0;
                end
            endcase

            r_ml_side <= r_tr_side;
            r_ml_ps   <= 62'(r_radius) * 62'(r_tr_smag);
            r_ml_pc   <= 62'(r_radius) * 62'(r_tr_cmag);
            r_ml_sneg <= r_tr_sneg;
            r_ml_cneg <= r_tr_cneg;
            r_ml_ts   <= n_ts_round[14:0];
            r_ml_tc   <= n_tc_round[14:0];
        end
    end

    // offset, saturation and output register
    function automatic logic [31:0] f_sat(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF)       f_sat = 32'h7FFF_FFFF;
        else if (v < -34'sh0_8000_0000) f_sat = 32'h8000_0000;
        else                            f_sat = v[31:0];
    endfunction

    logic [61:0]        n_rs, n_rc;
    logic signed [33:0] n_os, n_oc, n_px, n_py, n_pz;
    logic        [15:0] n_u, n_v;

    always_comb begin
        n_rs = (r_ml_ps + 62'h2000_0000) >> 30;
        n_rc = (r_ml_pc + 62'h2000_0000) >> 30;
        n_os = r_ml_sneg ? -$signed({2'b00, n_rs[31:0]}) : $signed({2'b00, n_rs[31:0]});
        n_oc = r_ml_cneg ? -$signed({2'b00, n_rc[31:0]}) : $signed({2'b00, n_rc[31:0]});
        if (r_ml_side.ctr) begin
            n_os = '0;
            n_oc = '0;
        end
        n_px = 34'(signed'(r_cx)) + n_os;
        n_py = 34'(signed'(r_cy)) + (r_plane ? 34'sd0 : n_oc);
        n_pz = 34'(signed'(r_cz)) + (r_plane ? n_oc : 34'sd0);
        n_u  = r_ml_sneg ? TEX_HALF - 16'(r_ml_ts) : TEX_HALF + 16'(r_ml_ts);
        n_v  = r_ml_cneg ? TEX_HALF + 16'(r_ml_tc) : TEX_HALF - 16'(r_ml_tc);
        if (r_ml_side.ctr) begin
            n_u = TEX_HALF;
            n_v = TEX_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_ml_side.err) begin
                o_vtx.pos_x       <= '0;
                o_vtx.pos_y       <= '0;
                o_vtx.pos_z       <= '0;
                o_vtx.tex_u       <= '0;
                o_vtx.tex_v       <= '0;
                o_vtx.colour_out  <= '0;
                o_vtx.tri_valid   <= 1'b0;
                o_vtx.tri_second  <= '0;
                o_vtx.tri_third   <= '0;
                o_vtx.index_error <= 1'b1;
            end else begin
                o_vtx.pos_x       <= f_sat(n_px);
                o_vtx.pos_y       <= f_sat(n_py);
                o_vtx.pos_z       <= f_sat(n_pz);
                o_vtx.tex_u       <= n_u;
                o_vtx.tex_v       <= n_v;
                o_vtx.colour_out  <= r_plane ? XZ_COLOUR : r_colour;
                o_vtx.tri_valid   <= !r_ml_side.ctr;
                o_vtx.tri_second  <= r_ml_side.ctr ? '0 : r_ml_side.k;
                o_vtx.tri_third   <= r_ml_side.ctr ? '0 : r_ml_side.third;
                o_vtx.index_error <= 1'b0;
            end
        end
    end

    assign o_vtx.valid = r_out_vld;

endmodule

>>> rtl/core/cfvg_series_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfvg_series_step
// One Taylor term of sine and cosine: multiply by x^2, divide by a constant
// through its reciprocal, accumulate. Three register stages.
// ----------------------------------------------------------------------------
module cfvg_series_step import cfvg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  t_side              i_side,
    input  logic        [31:0] i_x2,
    input  logic        [31:0] i_ts,
    input  logic        [31:0] i_tc,
    input  logic signed [33:0] i_as,
    input  logic signed [33:0] i_ac,
    input  logic        [8:0]  i_sdiv,
    input  logic        [31:0] i_srecip,
    input  logic        [8:0]  i_cdiv,
    input  logic        [31:0] i_crecip,
    input  logic               i_sub,
    output logic               o_vld,
    output t_side              o_side,
    output logic        [31:0] o_x2,
    output logic        [31:0] o_ts,
    output logic        [31:0] o_tc,
    output logic signed [33:0] o_as,
    output logic signed [33:0] o_ac
);

    logic [2:0]         r_vld;
    t_side              r_side [3];
    logic [31:0]        r_x2   [3];
    logic signed [33:0] r_as   [3];
    logic signed [33:0] r_ac   [3];
    logic [31:0]        r_ns1, r_nc1, r_ns2, r_nc2, r_qs2, r_qc2, r_ts3, r_tc3;

    logic [63:0] n_ps, n_pc, n_ms, n_mc;
    logic [31:0] n_rs, n_rc, n_ts, n_tc;

    always_comb begin
        n_ps = 64'(i_ts) * 64'(i_x2);
        n_pc = 64'(i_tc) * 64'(i_x2);
        n_ms = 64'(r_ns1) * 64'(i_srecip);
        n_mc = 64'(r_nc1) * 64'(i_crecip);
        // reciprocal estimate is at most one low
        n_rs = r_ns2 - 32'(r_qs2 * 32'(i_sdiv));
        n_rc = r_nc2 - 32'(r_qc2 * 32'(i_cdiv));
        n_ts = r_qs2 + 32'(n_rs >= 32'(i_sdiv));
        n_tc = r_qc2 + 32'(n_rc >= 32'(i_cdiv));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_x2[0]   <= i_x2;
            r_as[0]   <= i_as;
            r_ac[0]   <= i_ac;
            r_ns1     <= n_ps[61:30];
            r_nc1     <= n_pc[61:30];

            r_side[1] <= r_side[0];
            r_x2[1]   <= r_x2[0];
            r_as[1]   <= r_as[0];
            r_ac[1]   <= r_ac[0];
            r_ns2     <= r_ns1;
            r_nc2     <= r_nc1;
            r_qs2     <= n_ms[63:32];
            r_qc2     <= n_mc[63:32];

            r_side[2] <= r_side[1];
            r_x2[2]   <= r_x2[1];
            r_ts3     <= n_ts;
            r_tc3     <= n_tc;
            if (i_sub) begin
                r_as[2] <= r_as[1] - $signed({2'b00, n_ts});
                r_ac[2] <= r_ac[1] - $signed({2'b00, n_tc});
            end else begin
                r_as[2] <= r_as[1] + $signed({2'b00, n_ts});
                r_ac[2] <= r_ac[1] + $signed({2'b00, n_tc});
            end
        end
    end

    assign o_vld  = r_vld[2];
    assign o_side = r_side[2];
    assign o_x2   = r_x2[2];
    assign o_ts   = r_ts3;
    assign o_tc   = r_tc3;
    assign o_as   = r_as[2];
    assign o_ac   = r_ac[2];

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the circle fan vertex generator: a directed table of vertex
// numbers and register settings, then random vertex streams under random
// sender bursts and receiver stalls, each result checked against a local
// fixed-point model of the rim geometry.
// ----------------------------------------------------------------------------
module tb;
    import cfvg_pkg::*;

    localparam int LATENCY   = 46;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [15:0] tex_u;
        logic        [15:0] tex_v;
        logic        [31:0] colour_out;
        logic               tri_valid;
        logic        [12:0] tri_second;
        logic        [12:0] tri_third;
        logic               index_error;
    } t_vertex;

    // one directed row: vertex number, optional typed-in result
    typedef struct {
        logic [12:0] k;
        bit          fixed;
        t_vertex     res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    cfvg_vtx_in_if  vin();
    cfvg_vtx_out_if vout();

    circle_fan_vertex_generator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_vtx      (vin.sink),
        .o_vtx      (vout.source)
    );

    always #10 i_clk = ~i_clk;

    // circle registers as the block should hold them
    logic [31:0] cir_cx, cir_cy, cir_cz, cir_colour;
    logic [30:0] cir_radius;
    logic [12:0] cir_segs;
    logic        cir_plane;

    t_vertex   vertex_queue[$];
    int        errors = 0;
    longint    cycles = 0;
    bit        hold_off = 1'b0;

    function automatic void sincos_q30(input logic [63:0] x,
                                       output longint s, output longint c);
        logic [63:0] x2, ts, tc;
        longint as_, ac;
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'd1 << 30;
        as_ = longint'(x);
        ac = longint'(64'd1 << 30);
        for (int n = 1; n <= 8; n++) begin
            ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
            tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
                as_ -= longint'(ts);
                ac -= longint'(tc);
            end else begin
                as_ += longint'(ts);
                ac += longint'(tc);
            end
        end
        s = as_ < 0 ? 0 : (as_ > (64'sd1 <<< 30) ? (64'sd1 <<< 30) : as_);
        c = ac < 0 ? 0 : (ac > (64'sd1 <<< 30) ? (64'sd1 <<< 30) : ac);
    endfunction

    function automatic longint rim_offset(input longint t);
        logic [63:0] mag;
        longint off;
        mag = t < 0 ? -t : t;
        off = longint'((64'(cir_radius) * mag + (64'd1 << 29)) >> 30);
        return t < 0 ? -off : off;
    endfunction

    function automatic longint tex_offset(input longint t);
        logic [63:0] mag;
        longint v;
        mag = t < 0 ? -t : t;
        v = longint'((mag + (64'd1 << 15)) >> 16);
        return t < 0 ? -v : v;
    endfunction

    function automatic logic [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic t_vertex predict_vertex(input logic [12:0] k);
        t_vertex r;
        logic [63:0] segs, p, f, x;
        logic [1:0] q;
        longint cx, cy, cz, s, c, bs, bc, u, v;
        r = '0;
        segs = cir_segs < SEG_MIN ? 64'(SEG_MIN) : (cir_segs > SEG_MAX ? 64'(SEG_MAX)
                                                                    : 64'(cir_segs));
        if (64'(k) > segs) begin
            r.index_error = 1'b1;
            return r;
        end
        cx = longint'($signed(cir_cx));
        cy = longint'($signed(cir_cy));
        cz = longint'($signed(cir_cz));
        u = 16384;
        v = 16384;
        if (k != 0) begin
            p = (64'(k - 1) << ANGLE_BITS) / segs;
            q = p[ANGLE_BITS-1 -: 2];
            f = p & ((64'd1 << (ANGLE_BITS - 2)) - 1);
            x = ((f << (32 - ANGLE_BITS)) * 64'h6487ED51) >> 30;
            sincos_q30(x, bs, bc);
            case (q)
                2'd0: begin s = bs; c = bc; end
                2'd1: begin s = bc; c = -bs; end
                2'd2: begin s = -bs; c = -bc; end
                default: begin s = -bc; c = bs; end
            endcase
            cx += rim_offset(s);
            if (cir_plane) cz += rim_offset(c);
            else cy += rim_offset(c);
            u = 16384 + tex_offset(s);
            v = 16384 - tex_offset(c);
            r.tri_valid = 1'b1;
            r.tri_second = k;
            r.tri_third = (64'(k) == segs) ? 13'd1 : k + 13'd1;
        end
        r.pos_x = clip32(cx);
        r.pos_y = clip32(cy);
        r.pos_z = clip32(cz);
        r.tex_u = u[15:0];
        r.tex_v = v[15:0];
        r.colour_out = cir_plane ? XZ_COLOUR : cir_colour;
        return r;
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_CENTER_X: cir_cx = val;
            REG_CENTER_Y: cir_cy = val;
            REG_CENTER_Z: cir_cz = val;
            REG_RADIUS:   cir_radius = val[30:0];
            REG_SEGMENTS: cir_segs = val[12:0];
            REG_COLOUR:   cir_colour = val;
            default:      cir_plane = val[0];
        endcase
    endtask

    // wait until every expected vertex has come back
    task automatic drain();
        while (vertex_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // push one vertex number through, sender gaps at random
    task automatic send_vertex(input logic [12:0] k, input bit burst);
        if (!burst) begin
            vin.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        vin.valid <= 1'b1;
        vin.vertex_number <= k;
        @(posedge i_clk);
        while (!vin.ready) @(posedge i_clk);
    endtask

    task automatic send_stream(input int n, input bit deep);
        int left;
        logic [12:0] k;
        bit burst;
        int segs;
        left = 0;
        segs = cir_segs < 3 ? 3 : (cir_segs > 4096 ? 4096 : cir_segs);
        for (int i = 0; i < n; i++) begin
            if (left == 0) begin
                left = $urandom_range(1, 20);
                burst = ($urandom_range(0, 3) == 0);
            end else begin
                burst = 1'b1;
            end
            left--;
            if (deep && $urandom_range(0, 9) != 0) k = 13'($urandom_range(0, segs));
            else k = 13'($urandom);
            send_vertex(k, burst);
        end
        vin.valid <= 1'b0;
    endtask

    // expected results recorded at each input transfer
    always @(posedge i_clk) begin
        if (i_rst_n && vin.valid && vin.ready) begin
            vertex_queue.insert(vertex_queue.size(), predict_vertex(vin.vertex_number));
        end
    end

    // compare each result transfer
    always @(posedge i_clk) begin
        t_vertex e;
        if (i_rst_n && vout.valid && vout.ready) begin
            if (vertex_queue.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                e = vertex_queue.pop_front();
                if (vout.pos_x !== e.pos_x) begin
                    $error("pos_x exp %h got %h", e.pos_x, vout.pos_x); errors++;
                end
                if (vout.pos_y !== e.pos_y) begin
                    $error("pos_y exp %h got %h", e.pos_y, vout.pos_y); errors++;
                end
                if (vout.pos_z !== e.pos_z) begin
                    $error("pos_z exp %h got %h", e.pos_z, vout.pos_z); errors++;
                end
                if (vout.tex_u !== e.tex_u) begin
                    $error("tex_u exp %h got %h", e.tex_u, vout.tex_u); errors++;
                end
                if (vout.tex_v !== e.tex_v) begin
                    $error("tex_v exp %h got %h", e.tex_v, vout.tex_v); errors++;
                end
                if (vout.colour_out !== e.colour_out) begin
                    $error("colour_out exp %h got %h", e.colour_out, vout.colour_out);
                    errors++;
                end
                if (vout.tri_valid !== e.tri_valid) begin
                    $error("tri_valid exp %b got %b", e.tri_valid, vout.tri_valid);
                    errors++;
                end
                if (vout.tri_second !== e.tri_second) begin
                    $error("tri_second exp %0d got %0d", e.tri_second, vout.tri_second);
                    errors++;
                end
                if (vout.tri_third !== e.tri_third) begin
                    $error("tri_third exp %0d got %0d", e.tri_third, vout.tri_third);
                    errors++;
                end
                if (vout.index_error !== e.index_error) begin
                    $error("index_error exp %b got %b", e.index_error, vout.index_error);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    always @(posedge i_clk) begin
        int hold_cnt;
        bit hold_done;
        if (hold_off && !hold_done) begin
            vout.ready <= 1'b0;
            hold_cnt++;
            if (hold_cnt > 150) hold_done = 1'b1;
        end else begin
            hold_cnt = 0;
            vout.ready <= (cycles % 64 < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("** circle_fan_vertex_generator: FAILED **");
            $finish;
        end
    end

    // directed table; typed-in results are held against the prediction
    t_row dir_rows[$];

    task automatic add_row(input logic [12:0] k);
        t_row r;
        r.k = k;
        r.fixed = 1'b0;
        r.res = '0;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    initial begin
        t_row r;
        t_vertex p;
        vin.valid = 1'b0;
        vin.vertex_number = '0;
        cir_cx = '0; cir_cy = '0; cir_cz = '0;
        cir_radius = 31'd65536; cir_segs = 13'd32;
        cir_colour = 32'hFFFF_FFFF; cir_plane = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: centre vertex, first rim vertex, out of range
        r.k = 13'd0; r.fixed = 1'b1; r.res = '0;
        r.res.tex_u = TEX_HALF; r.res.tex_v = TEX_HALF; r.res.colour_out = 32'hFFFF_FFFF;
        dir_rows.insert(dir_rows.size(), r);
        r.k = 13'd1; r.res = '0;
        r.res.pos_y = 32'sd65536; r.res.tex_u = TEX_HALF; r.res.tex_v = 16'd0;
        r.res.colour_out = 32'hFFFF_FFFF; r.res.tri_valid = 1'b1;
        r.res.tri_second = 13'd1; r.res.tri_third = 13'd2;
        dir_rows.insert(dir_rows.size(), r);
        r.k = 13'd33; r.res = '0; r.res.index_error = 1'b1;
        dir_rows.insert(dir_rows.size(), r);
        r.k = 13'h1FFF;
        dir_rows.insert(dir_rows.size(), r);
        add_row(13'd9); add_row(13'd17); add_row(13'd25); add_row(13'd32);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].fixed) begin
                p = predict_vertex(dir_rows[i].k);
                if (p !== dir_rows[i].res) begin
                    $error("prediction of vertex %0d disagrees with table", dir_rows[i].k);
                    errors++;
                end
            end
            send_vertex(dir_rows[i].k, 1'b1);
        end
        vin.valid <= 1'b0;
        drain();

        // extremes: huge radius saturates, segment count clamps low
        write_reg(REG_CENTER_X, 32'h7FFF_FFFF);
        write_reg(REG_CENTER_Y, 32'h8000_0000);
        write_reg(REG_CENTER_Z, 32'h8000_0000);
        write_reg(REG_RADIUS, 32'h7FFF_FFFF);
        write_reg(REG_SEGMENTS, 32'd0);
        write_reg(REG_COLOUR, 32'h0000_0000);
        write_reg(REG_PLANE, 32'd1);
        for (int k = 0; k <= 4; k++) send_vertex(13'(k), 1'b1);
        vin.valid <= 1'b0;
        drain();

        // zero radius, maximum segment count, last vertex and one past it
        write_reg(REG_RADIUS, 32'd0);
        write_reg(REG_SEGMENTS, 32'h1FFF);
        write_reg(REG_PLANE, 32'd0);
        send_vertex(13'd4096, 1'b1);
        send_vertex(13'd4097, 1'b1);
        send_vertex(13'd2049, 1'b1);
        vin.valid <= 1'b0;
        drain();

        // random phases over several circle settings
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_CENTER_X, $urandom);
            write_reg(REG_CENTER_Y, $urandom);
            write_reg(REG_CENTER_Z, $urandom);
            write_reg(REG_RADIUS, ph == 0 ? 32'h7FFF_FFFF : {1'b0, 31'($urandom)} >> $urandom_range(0, 14));
            write_reg(REG_SEGMENTS, ph == 1 ? 32'd3 : (ph == 2 ? 32'd4096 : $urandom_range(0, 200)));
            write_reg(REG_COLOUR, $urandom);
            write_reg(REG_PLANE, $urandom);
            if (ph == 2) begin
                hold_off <= 1'b1;
            end
            send_stream(80, 1'b1);
            drain();
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && vertex_queue.size() == 0) begin
            $display("** circle_fan_vertex_generator: PASSED **");
        end else begin
            $display("** circle_fan_vertex_generator: FAILED **");
        end
        $finish;
    end
endmodule
